/* src/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared constants, codes and pipeline sideband type for the converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int HUE_FRACTION_BITS = 6;
  localparam int CH_W = 8;
  localparam int HUE_W = 15;
  localparam int SECTOR_UNITS = 60 << HUE_FRACTION_BITS;
  localparam int HUE_TURN = 6 * SECTOR_UNITS;
  localparam int HQ_W = $clog2(SECTOR_UNITS + 1);
  localparam int QUO_W = (HQ_W > CH_W) ? HQ_W : CH_W;
  localparam int NUM_W = CH_W + QUO_W;
  localparam int HSUM_W = $clog2(HUE_TURN + 1);
  localparam int IN_W = 3 * CH_W;
  localparam int OUT_W = ((HUE_W + 2 * CH_W + 7) / 8) * 8;

  localparam logic [1:0] SEL_RED = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE = 2'd2;

  typedef struct packed {
    logic [1:0] sel;
    logic neg;
    logic dzero;
    logic [CH_W-1:0] hi;
  } side_t;

endpackage

/* src/rhc_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
module rhc_div
  import rhc_pkg::*;
(
  input  logic             clk,
  input  logic [QUO_W-1:0] en,
  input  logic [NUM_W-1:0] num,
  input  logic [CH_W-1:0]  den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem [QUO_W];
  logic [CH_W-1:0]  dv  [QUO_W];
  logic [QUO_W-1:0] qv  [QUO_W];

  genvar j;
  generate
    for (j = 0; j < QUO_W; j++) begin : g_stage
      logic [NUM_W-1:0] rem_in;
      logic [CH_W-1:0]  den_in;
      logic [QUO_W-1:0] q_in;
      logic [NUM_W-1:0] trial;
      logic             fits;

      if (j == 0) begin : g_first
        assign rem_in = num;
        assign den_in = den;
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem[j-1];
        assign den_in = dv[j-1];
        assign q_in   = qv[j-1];
      end

      assign trial = NUM_W'(den_in) << (QUO_W - 1 - j);
      assign fits  = (rem_in >= trial);

      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem[j] <= fits ? (rem_in - trial) : rem_in;
          dv[j]  <= den_in;
          qv[j]  <= q_in | (fits ? (QUO_W'(1) << (QUO_W - 1 - j)) : '0);
        end
      end
    end
  endgenerate

  assign quo = qv[QUO_W-1];

endmodule

/* src/rgb_to_hsv_converter_unit.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one 8-bit RGB pixel per clock, unless stalled, to fixed-point HSV.
// ----------------------------------------------------------------------------
// The unit accepts one pixel per clock while the output is not stalled, and
// returns one result per pixel, in order, through the input register, the
// max/min stage, the numerator stage, twelve divider stages of one quotient
// bit each and the output register. Two pipelined restoring dividers run
// side by side, one for hue and one for saturation. Each stage holds while
// the stage after it is full and stalled, so empty slots are filled during a
// downstream stall. Hue is in 1/64-degree units, 0 to 23039.
module rgb_to_hsv_converter_unit
  import rhc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // red, green, blue
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // hue, saturation, brightness, zero pad
);

  localparam int NSTG = QUO_W + 4;
  localparam int DIV0 = 3;
  localparam int DLAST = DIV0 + QUO_W - 1;

  logic [NSTG-1:0] valid;
  logic [NSTG:0]   ready;

  assign ready[NSTG] = m_tready;

  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_rdy
      assign ready[k] = !valid[k] || ready[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign s_tready = ready[0];

  logic [CH_W-1:0] r0, g0, b0;

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      r0 <= s_tdata[0 +: CH_W];
      g0 <= s_tdata[CH_W +: CH_W];
      b0 <= s_tdata[2*CH_W +: CH_W];
    end
  end

  logic [CH_W-1:0] hi_c, lo_c, pa_c, pb_c;
  logic [1:0]      sel_c;
  logic [CH_W-1:0] hi1, lo1, pa1, pb1;
  logic [1:0]      sel1;

  always_comb begin
    hi_c = r0;
    lo_c = r0;
    if (g0 > hi_c) hi_c = g0;
    if (b0 > hi_c) hi_c = b0;
    if (g0 < lo_c) lo_c = g0;
    if (b0 < lo_c) lo_c = b0;
    if (hi_c == r0) begin
      sel_c = SEL_RED;
      pa_c  = g0;
      pb_c  = b0;
    end else if (hi_c == g0) begin
      sel_c = SEL_GREEN;
      pa_c  = b0;
      pb_c  = r0;
    end else begin
      sel_c = SEL_BLUE;
      pa_c  = r0;
      pb_c  = g0;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      hi1  <= hi_c;
      lo1  <= lo_c;
      pa1  <= pa_c;
      pb1  <= pb_c;
      sel1 <= sel_c;
    end
  end

  logic [CH_W-1:0]  delta_c, absd_c;
  logic             neg_c;
  logic [NUM_W-1:0] hnum2, snum2;
  logic [CH_W-1:0]  delta2;
  side_t            side [NSTG];

  assign delta_c = hi1 - lo1;
  assign neg_c   = (pa1 < pb1);
  assign absd_c  = neg_c ? (pb1 - pa1) : (pa1 - pb1);

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      hnum2         <= NUM_W'(SECTOR_UNITS) * NUM_W'(absd_c);
      snum2         <= (NUM_W'(delta_c) << CH_W) - NUM_W'(delta_c);
      delta2        <= delta_c;
      side[2].sel   <= sel1;
      side[2].neg   <= neg_c;
      side[2].dzero <= (delta_c == '0);
      side[2].hi    <= hi1;
    end
  end

  generate
    for (k = DIV0; k <= DLAST; k++) begin : g_side
      always_ff @(posedge clk) begin
        if (ready[k]) begin
          side[k] <= side[k-1];
        end
      end
    end
  endgenerate

  logic [QUO_W-1:0] hquo, squo;

  rhc_div u_hdiv (
    .clk (clk),
    .en  (ready[DIV0 +: QUO_W]),
    .num (hnum2),
    .den (delta2),
    .quo (hquo)
  );

  rhc_div u_sdiv (
    .clk (clk),
    .en  (ready[DIV0 +: QUO_W]),
    .num (snum2),
    .den (side[2].hi),
    .quo (squo)
  );

  side_t             sd;
  logic [HSUM_W-1:0] q_ext, base, hue_c;
  logic [HUE_W-1:0]  hue_o;
  logic [CH_W-1:0]   sat_o, bri_o;

  assign sd    = side[DLAST];
  assign q_ext = HSUM_W'(hquo);

  always_comb begin
    case (sd.sel)
      SEL_RED:   base = '0;
      SEL_GREEN: base = HSUM_W'(2 * SECTOR_UNITS);
      SEL_BLUE:  base = HSUM_W'(4 * SECTOR_UNITS);
      default:   base = '0;
    endcase
    if (sd.dzero) begin
      hue_c = '0;
    end else if (!sd.neg) begin
      hue_c = base + q_ext;
    end else if (sd.sel == SEL_RED) begin
      hue_c = (q_ext == '0) ? '0 : (HSUM_W'(HUE_TURN) - q_ext);
    end else begin
      hue_c = base - q_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[NSTG-1]) begin
      hue_o <= HUE_W'(hue_c);
      sat_o <= (sd.hi == '0) ? '0 : squo[CH_W-1:0];
      bri_o <= sd.hi;
    end
  end

  assign m_tvalid = valid[NSTG-1];
  assign m_tdata  = OUT_W'({bri_o, sat_o, hue_o});

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    ((&valid) && !m_tready) |-> !s_tready)
    else $error("input accepted while the pipeline is full and stalled");

  a_gray_hue_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && sat_o == '0) |-> (hue_o == '0))
    else $error("gray pixel produced nonzero hue");

  a_black_sat_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && bri_o == '0) |-> (sat_o == '0))
    else $error("black pixel produced nonzero saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (HUE_TURN <= (1 << HUE_W))) |-> (int'(hue_o) < HUE_TURN))
    else $error("hue outside a full turn");

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Streams directed and random pixels through the converter with random
// stalls on both sides. A scoreboard class computes the expected hue,
// saturation and brightness of every accepted pixel and checks each result
// transaction against the oldest pending expectation, in order.
// ----------------------------------------------------------------------------
module testbench
  import rhc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1330;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  class hsv_scoreboard;
    typedef struct {
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  sat;
      logic [CH_W-1:0]  val;
    } hsv_pixel_t;

    hsv_pixel_t hsv_expected_q[$];
    int errors = 0;

    function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      hsv_pixel_t px;
      int unit;
      int ri, gi, bi;
      int top, bottom, delta, h, s;
      unit = 60 << HUE_FRACTION_BITS;
      ri = r;
      gi = g;
      bi = b;
      top = ri;
      bottom = ri;
      if (gi > top) top = gi;
      if (bi > top) top = bi;
      if (gi < bottom) bottom = gi;
      if (bi < bottom) bottom = bi;
      delta = top - bottom;
      s = (top > 0) ? (delta * 255) / top : 0;
      if (delta == 0) begin
        h = 0;
      end else if (top == ri) begin
        h = (unit * (gi - bi)) / delta;
        if (h < 0) h = h + 6 * unit;
      end else if (top == gi) begin
        h = (unit * (bi - ri)) / delta + 2 * unit;
      end else begin
        h = (unit * (ri - gi)) / delta + 4 * unit;
      end
      px.red = r;
      px.green = g;
      px.blue = b;
      px.hue = h[HUE_W-1:0];
      px.sat = s[CH_W-1:0];
      px.val = top[CH_W-1:0];
      hsv_expected_q.push_back(px);
    endfunction

    function void report_field(string name, hsv_pixel_t px, int exp_v, int act_v);
      $display("%0t: %s mismatch for pixel r=%0d g=%0d b=%0d: expected %0d, actual %0d",
               $time, name, px.red, px.green, px.blue, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      hsv_pixel_t px;
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0] sat, val;
      hue = data[HUE_W-1:0];
      sat = data[HUE_W +: CH_W];
      val = data[HUE_W+CH_W +: CH_W];
      if (hsv_expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual hue=%0d sat=%0d val=%0d",
                 $time, hue, sat, val);
        errors++;
        return;
      end
      px = hsv_expected_q.pop_front();
      if (hue !== px.hue) report_field("hue", px, px.hue, hue);
      if (sat !== px.sat) report_field("saturation", px, px.sat, sat);
      if (val !== px.val) report_field("brightness", px, px.val, val);
    endfunction

    function int pending();
      return hsv_expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  hsv_scoreboard sb = new();

  rgb_to_hsv_converter_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= (stall_left == 0);
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(r, g, b);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] corner_value();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      5: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
    int top, low, base;
    case ($urandom_range(0, 9))
      4: begin
        r = 8'($urandom);
        g = r;
        b = r;
      end
      5, 6: begin
        top = $urandom_range(1, 255);
        low = $urandom_range(0, top);
        case ($urandom_range(0, 2))
          0: begin r = 8'(top); g = 8'(top); b = 8'(low); end
          1: begin r = 8'(top); g = 8'(low); b = 8'(top); end
          default: begin r = 8'(low); g = 8'(top); b = 8'(top); end
        endcase
      end
      7: begin
        r = corner_value();
        g = corner_value();
        b = corner_value();
      end
      8: begin
        base = $urandom_range(2, 253);
        r = 8'(base + $urandom_range(0, 2) - 1);
        g = 8'(base + $urandom_range(0, 2) - 1);
        b = 8'(base + $urandom_range(0, 2) - 1);
      end
      default: begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end
    endcase
  endtask

  initial begin
    logic [7:0] r, g, b;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd0, 8'd254, 8'd255);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd1, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd170, 8'd85, 8'd255);
    wait_for_drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == (N_RANDOM * 85) / 100) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      if (n == 500) wait_for_drain();
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
